// ===== rtl/sbic_pkg.sv =====
// ----------------------------------------------------------------------------
// sbic_pkg
// Shared types and constants of the sparse bitmap image checker: the input
// and result beat layouts, the parse phases and the status codes.
// ----------------------------------------------------------------------------
package sbic_pkg;

    // bits covered by one node map
    localparam int unsigned MAP_BITS = 64;
    localparam logic [31:0] MAP_BITS_W = 32'(MAP_BITS);
    localparam logic [31:0] MAP_MASK = 32'(MAP_BITS - 1);

    // parse phase: which word of the image comes next
    typedef enum logic [2:0] {
        PH_SIZE  = 3'd0,
        PH_HIGH  = 3'd1,
        PH_COUNT = 3'd2,
        PH_START = 3'd3,
        PH_MLO   = 3'd4,
        PH_MHI   = 3'd5
    } t_phase;

    // status reported with every word
    typedef enum logic [3:0] {
        ST_CONT      = 4'd0,
        ST_OK        = 4'd1,
        ST_BAD_SIZE  = 4'd2,
        ST_HIGH_MIS  = 4'd3,
        ST_TRUNC     = 4'd4,
        ST_START_MIS = 4'd5,
        ST_BEYOND    = 4'd6,
        ST_EMPTY     = 4'd7,
        ST_ORDER     = 4'd8
    } t_status;

    // input beat
    typedef struct packed {
        logic [31:0] word;
        logic        last_word;
    } t_in_item;

    // result beat
    typedef struct packed {
        t_status     status;
        logic        node_valid;
        logic [31:0] node_start;
        logic [63:0] node_map;
        logic [31:0] high_bit;
    } t_out_item;

endpackage

// ===== rtl/sbic_step.sv =====
// ----------------------------------------------------------------------------
// sbic_step
// Input register and parser state. Each registered word is checked against
// the current phase and the header/node state in one pass, and the result
// beat is handed to the output queue as the state moves on.
// ----------------------------------------------------------------------------
module sbic_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  sbic_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_res_valid,
    output sbic_pkg::t_out_item o_res_item,
    input  logic                i_res_stall
);

    // input register
    logic               r_in_valid;
    sbic_pkg::t_in_item r_in;
    logic               w_adv;

    // parser state
    sbic_pkg::t_phase r_phase, n_phase;
    logic [31:0]      r_header_high, n_header_high;
    logic [31:0]      r_nodes_left, n_nodes_left;
    logic [31:0]      r_cur_start, n_cur_start;
    logic [31:0]      r_map_low, n_map_low;
    logic [31:0]      r_prev_start, n_prev_start;
    logic             r_have_prev, n_have_prev;
    logic             r_size_bad, n_size_bad;

    // per-word results
    sbic_pkg::t_status w_status;
    logic              w_node_valid;
    logic [31:0]       w_node_start;
    logic [63:0]       w_node_map;
    logic [63:0]       w_map;
    logic [31:0]       w_nodes_dec;
    logic [31:0]       w_start_limit;

    assign w_adv       = r_in_valid && !i_res_stall;
    assign o_in_stall  = r_in_valid && i_res_stall;
    assign o_res_valid = r_in_valid;

    assign w_map         = {r_in.word, r_map_low};
    assign w_nodes_dec   = r_nodes_left - 32'd1;
    assign w_start_limit = r_header_high - sbic_pkg::MAP_BITS_W;

    // input register load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // status and node outputs for the registered word
    always_comb begin
        w_status     = sbic_pkg::ST_CONT;
        w_node_valid = 1'b0;
        w_node_start = '0;
        w_node_map   = '0;
        unique case (r_phase)
            sbic_pkg::PH_HIGH: begin
                if (r_in.last_word) w_status = sbic_pkg::ST_TRUNC;
            end
            sbic_pkg::PH_COUNT: begin
                priority if (r_size_bad) w_status = sbic_pkg::ST_BAD_SIZE;
                else if (r_header_high == '0) w_status = sbic_pkg::ST_OK;
                else if ((r_header_high & sbic_pkg::MAP_MASK) != '0)
                    w_status = sbic_pkg::ST_HIGH_MIS;
                else if (r_in.word == '0) w_status = sbic_pkg::ST_OK;
                else if (r_in.last_word) w_status = sbic_pkg::ST_TRUNC;
                else w_status = sbic_pkg::ST_CONT;
            end
            sbic_pkg::PH_START: begin
                priority if ((r_in.word & sbic_pkg::MAP_MASK) != '0)
                    w_status = sbic_pkg::ST_START_MIS;
                else if (r_in.word > w_start_limit) w_status = sbic_pkg::ST_BEYOND;
                else if (r_in.last_word) w_status = sbic_pkg::ST_TRUNC;
                else w_status = sbic_pkg::ST_CONT;
            end
            sbic_pkg::PH_MLO: begin
                if (r_in.last_word) w_status = sbic_pkg::ST_TRUNC;
            end
            sbic_pkg::PH_MHI: begin
                priority if (w_map == '0) w_status = sbic_pkg::ST_EMPTY;
                else if (r_have_prev && (r_cur_start <= r_prev_start))
                    w_status = sbic_pkg::ST_ORDER;
                else begin
                    w_node_valid = 1'b1;
                    w_node_start = r_cur_start;
                    w_node_map   = w_map;
                    if (w_nodes_dec == '0) w_status = sbic_pkg::ST_OK;
                    else if (r_in.last_word) w_status = sbic_pkg::ST_TRUNC;
                end
            end
            default: begin
                if (r_in.last_word) w_status = sbic_pkg::ST_TRUNC;
            end
        endcase
    end

    // next parser state
    always_comb begin
        n_phase       = r_phase;
        n_header_high = r_header_high;
        n_nodes_left  = r_nodes_left;
        n_cur_start   = r_cur_start;
        n_map_low     = r_map_low;
        n_prev_start  = r_prev_start;
        n_have_prev   = r_have_prev;
        n_size_bad    = r_size_bad;
        unique case (r_phase)
            sbic_pkg::PH_HIGH: begin
                n_header_high = r_in.word;
                n_phase       = sbic_pkg::PH_COUNT;
            end
            sbic_pkg::PH_COUNT: begin
                n_nodes_left = r_in.word;
                n_have_prev  = 1'b0;
                n_prev_start = '0;
                n_phase      = sbic_pkg::PH_START;
            end
            sbic_pkg::PH_START: begin
                n_cur_start = r_in.word;
                n_phase     = sbic_pkg::PH_MLO;
            end
            sbic_pkg::PH_MLO: begin
                n_map_low = r_in.word;
                n_phase   = sbic_pkg::PH_MHI;
            end
            sbic_pkg::PH_MHI: begin
                if (w_node_valid) begin
                    n_prev_start = r_cur_start;
                    n_have_prev  = 1'b1;
                    n_nodes_left = w_nodes_dec;
                end
                n_phase = sbic_pkg::PH_START;
            end
            default: begin
                n_size_bad = (r_in.word != sbic_pkg::MAP_BITS_W);
                n_phase    = sbic_pkg::PH_HIGH;
            end
        endcase
        // any terminal status restarts at a fresh header
        if (w_status != sbic_pkg::ST_CONT) begin
            n_phase      = sbic_pkg::PH_SIZE;
            n_size_bad   = 1'b0;
            n_have_prev  = 1'b0;
            n_nodes_left = '0;
        end
    end

    // state update when the word moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= sbic_pkg::PH_SIZE;
            r_header_high <= '0;
            r_nodes_left  <= '0;
            r_cur_start   <= '0;
            r_map_low     <= '0;
            r_prev_start  <= '0;
            r_have_prev   <= 1'b0;
            r_size_bad    <= 1'b0;
        end else if (w_adv) begin
            r_phase       <= n_phase;
            r_header_high <= n_header_high;
            r_nodes_left  <= n_nodes_left;
            r_cur_start   <= n_cur_start;
            r_map_low     <= n_map_low;
            r_prev_start  <= n_prev_start;
            r_have_prev   <= n_have_prev;
            r_size_bad    <= n_size_bad;
        end
    end

    // result beat
    always_comb begin
        o_res_item.status     = w_status;
        o_res_item.node_valid = w_node_valid;
        o_res_item.node_start = w_node_start;
        o_res_item.node_map   = w_node_map;
        o_res_item.high_bit   = n_header_high;
    end

endmodule

// ===== rtl/sbic_outq.sv =====
// ----------------------------------------------------------------------------
// sbic_outq
// Two-entry result queue. Holds a finished beat while the consumer stalls
// and keeps room for the next one, so the parser never waits on the output
// stall directly.
// ----------------------------------------------------------------------------
module sbic_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  sbic_pkg::t_out_item i_item,
    output logic                o_stall,
    output logic                o_valid,
    output sbic_pkg::t_out_item o_item,
    input  logic                i_stall
);

    sbic_pkg::t_out_item r_entry [2];
    logic [1:0]          r_count;
    logic                r_head;
    logic                w_push;
    logic                w_pop;
    logic                w_tail;

    assign o_stall = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_entry[r_head];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;
    assign w_tail  = r_head ^ r_count[0];

    // occupancy and read pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_head  <= 1'b0;
        end else begin
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
            if (w_pop) r_head <= ~r_head;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[w_tail] <= i_item;
        end
    end

endmodule

// ===== rtl/sparse_bitmap_image_checker_core.sv =====
// ----------------------------------------------------------------------------
// sparse_bitmap_image_checker_core
// An accepted input beat reaches its result beat on the output through
// the input register, then the two-entry result queue.
// Throughput: one word per cycle; a word is taken whenever the input
// register is free or draining into the queue.
// Reset: synchronous, active low; the parser waits for a map size word.
// ----------------------------------------------------------------------------
module sparse_bitmap_image_checker_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  sbic_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output sbic_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);

    logic                res_valid;
    sbic_pkg::t_out_item res_item;
    logic                res_stall;

    // word parser and checker
    sbic_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_res_valid (res_valid),
        .o_res_item  (res_item),
        .i_res_stall (res_stall)
    );

    // result queue
    sbic_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_item  (res_item),
        .o_stall (res_stall),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .i_stall (i_out_stall)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sparse bitmap image checker. Serialized images,
// clean ones, ones with a single planted fault, and random noise words, are
// fed one word per beat. A local parser predicts the status, node and high bit
// result of every accepted word, and each result beat is compared with it
// field by field. Sender gaps and receiver stalls vary over the run.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned PRINT_CAP = 100;

    // kinds of image fault planted by the generator
    typedef enum int {
        FLT_NONE,
        FLT_SIZE,
        FLT_HIGH_ZERO,
        FLT_HIGH_MIS,
        FLT_COUNT_ZERO,
        FLT_START_MIS,
        FLT_BEYOND,
        FLT_EMPTY,
        FLT_ORDER,
        FLT_TRUNC
    } t_fault;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    sbic_pkg::t_in_item  in_item = '0;
    logic                in_stall;
    logic                out_valid;
    sbic_pkg::t_out_item out_item;
    logic                out_stall = 1'b0;

    // stimulus and scoreboard
    sbic_pkg::t_in_item  pending_words[$];
    sbic_pkg::t_out_item due_results[$];
    sbic_pkg::t_out_item fresh_result;
    sbic_pkg::t_out_item want_result;
    logic        word_taken = 1'b0;
    logic        hold_off = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned words_queued = 0;
    int unsigned words_taken = 0;
    int unsigned results_checked = 0;
    int unsigned nodes_emitted = 0;
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;
    int unsigned status_seen[9];

    // local copy of the parser state
    sbic_pkg::t_phase ps_phase = sbic_pkg::PH_SIZE;
    logic [31:0] ps_high = '0;
    logic [31:0] ps_left = '0;
    logic [31:0] ps_cur_start = '0;
    logic [31:0] ps_map_lo = '0;
    logic [31:0] ps_prev_start = '0;
    logic        ps_have_prev = 1'b0;
    logic        ps_size_bad = 1'b0;

    sparse_bitmap_image_checker_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall)
    );

    always #1 i_clk = ~i_clk;

    // parse one word and work out its result beat
    task automatic parse_word(input sbic_pkg::t_in_item beat,
                              output sbic_pkg::t_out_item res);
        sbic_pkg::t_status st;
        logic [63:0]       joined;
        st = sbic_pkg::ST_CONT;
        res = '0;
        case (ps_phase)
            sbic_pkg::PH_HIGH: begin
                ps_high = beat.word;
                if (beat.last_word) st = sbic_pkg::ST_TRUNC;
                else ps_phase = sbic_pkg::PH_COUNT;
            end
            sbic_pkg::PH_COUNT: begin
                if (ps_size_bad) st = sbic_pkg::ST_BAD_SIZE;
                else if (ps_high == '0) st = sbic_pkg::ST_OK;
                else if ((ps_high & sbic_pkg::MAP_MASK) != '0) st = sbic_pkg::ST_HIGH_MIS;
                else if (beat.word == '0) st = sbic_pkg::ST_OK;
                else if (beat.last_word) st = sbic_pkg::ST_TRUNC;
                else begin
                    ps_left = beat.word;
                    ps_have_prev = 1'b0;
                    ps_prev_start = '0;
                    ps_phase = sbic_pkg::PH_START;
                end
            end
            sbic_pkg::PH_START: begin
                if ((beat.word & sbic_pkg::MAP_MASK) != '0) st = sbic_pkg::ST_START_MIS;
                else if (beat.word > ps_high - sbic_pkg::MAP_BITS_W)
                    st = sbic_pkg::ST_BEYOND;
                else if (beat.last_word) st = sbic_pkg::ST_TRUNC;
                else begin
                    ps_cur_start = beat.word;
                    ps_phase = sbic_pkg::PH_MLO;
                end
            end
            sbic_pkg::PH_MLO: begin
                ps_map_lo = beat.word;
                if (beat.last_word) st = sbic_pkg::ST_TRUNC;
                else ps_phase = sbic_pkg::PH_MHI;
            end
            sbic_pkg::PH_MHI: begin
                joined = {beat.word, ps_map_lo};
                if (joined == '0) st = sbic_pkg::ST_EMPTY;
                else if (ps_have_prev && ps_cur_start <= ps_prev_start)
                    st = sbic_pkg::ST_ORDER;
                else begin
                    res.node_valid = 1'b1;
                    res.node_start = ps_cur_start;
                    res.node_map = joined;
                    ps_prev_start = ps_cur_start;
                    ps_have_prev = 1'b1;
                    ps_left = ps_left - 32'd1;
                    if (ps_left == '0) st = sbic_pkg::ST_OK;
                    else if (beat.last_word) st = sbic_pkg::ST_TRUNC;
                    else ps_phase = sbic_pkg::PH_START;
                end
            end
            default: begin
                ps_size_bad = (beat.word != sbic_pkg::MAP_BITS_W);
                if (beat.last_word) st = sbic_pkg::ST_TRUNC;
                else ps_phase = sbic_pkg::PH_HIGH;
            end
        endcase
        // any terminal status rearms for a fresh header
        if (st != sbic_pkg::ST_CONT) begin
            ps_phase = sbic_pkg::PH_SIZE;
            ps_size_bad = 1'b0;
            ps_have_prev = 1'b0;
            ps_left = '0;
        end
        res.status = st;
        res.high_bit = ps_high;
    endtask

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("tb_top: mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic push_word(input logic [31:0] w, input logic last);
        sbic_pkg::t_in_item beat;
        beat.word = w;
        beat.last_word = last;
        pending_words.push_back(beat);
        words_queued++;
    endtask

    // nonzero map, biased towards sparse and lopsided patterns
    function automatic logic [63:0] pick_map();
        logic [63:0] m;
        case ($urandom_range(0, 5))
            0: m = 64'd1 << $urandom_range(0, 63);
            1: m = '1;
            2: m = {32'd0, 32'($urandom)};
            3: m = {32'($urandom), 32'd0};
            default: m = {32'($urandom), 32'($urandom)};
        endcase
        if (m == '0) m = 64'h8000_0000_0000_0000;
        return m;
    endfunction

    // build one image, plant the fault, cut it where the fault lands
    task automatic queue_image(input t_fault fault);
        logic [31:0] img[$];
        logic [31:0] hb;
        logic [63:0] m;
        int unsigned n, k, spare, skip, cursor;
        int          i, j, cut, last_at;
        case (fault)
            FLT_COUNT_ZERO: n = 0;
            FLT_START_MIS, FLT_BEYOND, FLT_EMPTY: n = $urandom_range(1, 6);
            FLT_ORDER: n = $urandom_range(2, 6);
            default: n = ($urandom_range(99) < 8) ? 0 : $urandom_range(1, 6);
        endcase
        if ($urandom_range(99) < 70) k = n + $urandom_range(0, 6);
        else k = $urandom_range(n, 32'h03FF_FFFF);
        hb = 32'(k) << 6;
        img.push_back(sbic_pkg::MAP_BITS_W);
        img.push_back(hb);
        img.push_back(32'(n));
        // strictly rising aligned starts below the high bit
        spare = k - n;
        cursor = 0;
        for (j = 0; j < int'(n); j++) begin
            skip = $urandom_range(0, spare / (n - j));
            if (j == int'(n) - 1 && $urandom_range(3) == 0) skip = spare;
            spare -= skip;
            img.push_back(32'(cursor + skip) << 6);
            cursor += skip + 1;
            m = pick_map();
            img.push_back(m[31:0]);
            img.push_back(m[63:32]);
        end
        cut = img.size() - 1;
        j = (n > 0) ? $urandom_range(0, n - 1) : 0;
        case (fault)
            FLT_SIZE: begin
                img[0] = ($urandom_range(1) == 0)
                       ? 32'($urandom)
                       : sbic_pkg::MAP_BITS_W ^ (32'd1 << $urandom_range(0, 31));
                cut = 2;
            end
            FLT_HIGH_ZERO: begin
                img[1] = '0;
                cut = 2;
            end
            FLT_HIGH_MIS: begin
                img[1] = (32'($urandom) & ~sbic_pkg::MAP_MASK)
                       | 32'($urandom_range(1, 63));
                cut = 2;
            end
            FLT_START_MIS: begin
                img[3 + 3 * j] = img[3 + 3 * j] | 32'($urandom_range(1, 63));
                cut = 3 + 3 * j;
            end
            FLT_BEYOND: begin
                img[3 + 3 * j] = hb + 32'($urandom_range(0, 3)) * 32'd64;
                cut = 3 + 3 * j;
            end
            FLT_EMPTY: begin
                img[4 + 3 * j] = '0;
                img[5 + 3 * j] = '0;
                cut = 5 + 3 * j;
            end
            FLT_ORDER: begin
                j = $urandom_range(1, n - 1);
                if ($urandom_range(1) == 0) img[3 + 3 * j] = img[3 * j];
                else img[3 + 3 * j] = 32'($urandom_range(0, img[3 * j] >> 6)) << 6;
                cut = 5 + 3 * j;
            end
            default: ;
        endcase
        // last word either truncates or rides on the terminal word
        last_at = -1;
        if (fault == FLT_TRUNC) begin
            last_at = $urandom_range(0, img.size() - 2);
            cut = last_at;
        end else if ($urandom_range(99) < 30) begin
            last_at = cut;
        end else if (fault != FLT_NONE && $urandom_range(99) < 10) begin
            cut = img.size() - 1;
        end
        for (i = 0; i <= cut; i++) push_word(img[i], i == last_at);
    endtask

    task automatic run_random(input int unsigned budget);
        int unsigned goal;
        int unsigned pick;
        goal = words_queued + budget;
        while (words_queued < goal) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                queue_image(FLT_NONE);
            end else if (pick < 90) begin
                queue_image(t_fault'($urandom_range(FLT_SIZE, FLT_TRUNC)));
            end else begin
                repeat ($urandom_range(1, 4))
                    push_word(($urandom_range(3) == 0) ? sbic_pkg::MAP_BITS_W
                                                       : 32'($urandom),
                              $urandom_range(7) == 0);
            end
        end
    endtask

    task automatic wait_sent();
        do @(negedge i_clk); while (words_taken != words_queued);
        @(posedge i_clk);
    endtask

    task automatic wait_results();
        do @(negedge i_clk); while (due_results.size() != 0);
        @(posedge i_clk);
    endtask

    // sender: holds a beat until taken, then idles or sends the next word
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || word_taken) begin
            if (!hold_off && pending_words.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_item <= pending_words.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= i_rst_n && ($urandom_range(99) < recv_idle_pct);
    end

    // result check first, then prediction of the word taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            results_checked++;
            if (due_results.size() == 0) begin
                flag_error($sformatf("result beat with nothing due, status %0d",
                                     out_item.status));
            end else begin
                want_result = due_results.pop_front();
                if (out_item.status !== want_result.status)
                    flag_error($sformatf("status %0d, predicted %0d",
                                         out_item.status, want_result.status));
                if (out_item.node_valid !== want_result.node_valid)
                    flag_error($sformatf("node_valid %b, predicted %b",
                                         out_item.node_valid, want_result.node_valid));
                if (out_item.node_start !== want_result.node_start)
                    flag_error($sformatf("node_start %h, predicted %h",
                                         out_item.node_start, want_result.node_start));
                if (out_item.node_map !== want_result.node_map)
                    flag_error($sformatf("node_map %h, predicted %h",
                                         out_item.node_map, want_result.node_map));
                if (out_item.high_bit !== want_result.high_bit)
                    flag_error($sformatf("high_bit %h, predicted %h",
                                         out_item.high_bit, want_result.high_bit));
            end
        end
        word_taken <= i_rst_n && in_valid && !in_stall;
        if (i_rst_n && in_valid && !in_stall) begin
            parse_word(in_item, fresh_result);
            due_results.push_back(fresh_result);
            words_taken++;
            status_seen[fresh_result.status]++;
            if (fresh_result.node_valid) nodes_emitted++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: timeout after %0d cycles", cycle_count);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 38;
        recv_idle_pct = 67;

        // directed: header outcomes, truncation, extreme high bit and count
        push_word(32'd64, 1'b0);
        push_word(32'd0, 1'b0);
        push_word(32'd7, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'd64, 1'b0);
        push_word(32'd1, 1'b0);
        push_word(32'd64, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'd5, 1'b0);
        push_word(32'd64, 1'b0);
        push_word(32'hFFFF_FFC0, 1'b0);
        push_word(32'd0, 1'b0);
        push_word(32'd64, 1'b0);
        push_word(32'h0000_0040, 1'b1);
        push_word(32'd64, 1'b0);
        push_word(32'hFFFF_FFC0, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'hFFFF_FF80, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'hFFFF_FFC0, 1'b0);
        push_word(32'd64, 1'b0);
        push_word(32'd128, 1'b0);
        push_word(32'd1, 1'b0);
        push_word(32'h0000_0040, 1'b0);
        push_word(32'd0, 1'b0);
        push_word(32'h8000_0000, 1'b1);

        // sender gappy, receiver stalling hard
        run_random(350);
        wait_sent();

        // sender held back until the block has drained
        hold_off = 1'b1;
        send_idle_pct = 67;
        recv_idle_pct = 38;
        run_random(350);
        wait_results();
        hold_off = 1'b0;
        wait_sent();

        // full rate both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(350);
        wait_sent();
        wait_results();
        repeat (8) @(posedge i_clk);

        $display("tb_top: %0d words parsed, %0d result beats checked, %0d nodes emitted",
                 words_taken, results_checked, nodes_emitted);
        $display(
            "tb_top: ok %0d size %0d high %0d trunc %0d start %0d beyond %0d empty %0d order %0d",
            status_seen[sbic_pkg::ST_OK], status_seen[sbic_pkg::ST_BAD_SIZE],
            status_seen[sbic_pkg::ST_HIGH_MIS], status_seen[sbic_pkg::ST_TRUNC],
            status_seen[sbic_pkg::ST_START_MIS], status_seen[sbic_pkg::ST_BEYOND],
            status_seen[sbic_pkg::ST_EMPTY], status_seen[sbic_pkg::ST_ORDER]);
        if (err_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
